// ----- hw/rtl/dgr_pkg.sv -----
// shared types, constants and font tables for the decimal digit glyph renderer
package dgr_pkg;

  localparam int unsigned CfgW      = 11;
  localparam int unsigned AddrW     = 4;
  localparam int unsigned DataW     = 32;
  localparam int unsigned NumDigits = 5;
  localparam int unsigned ValW      = 17;
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = 1;
  localparam int unsigned FifoCntW  = 2;

  // register indexes
  localparam logic [1:0] RegBufWidth  = 2'd0;
  localparam logic [1:0] RegBufHeight = 2'd1;
  localparam logic [1:0] RegRowStride = 2'd2;

  localparam logic [CfgW-1:0] BufWidthRst  = 11'd256;
  localparam logic [CfgW-1:0] BufHeightRst = 11'd192;
  localparam logic [CfgW-1:0] RowStrideRst = 11'd256;

  localparam logic [ValW-1:0] Wrap = 17'd100000;

  typedef struct packed {
    logic [CfgW-1:0] buf_width;
    logic [CfgW-1:0] buf_height;
    logic [CfgW-1:0] row_stride;
  } dgr_cfg_t;

  typedef struct packed {
    logic signed [12:0]       org_x;
    logic signed [12:0]       org_y;
    logic [2:0]               ndig;
    logic                     big_font;
    logic [NumDigits-1:0][3:0] digits;
    logic [15:0]              color;
  } dgr_job_t;

  // multiples of each decimal weight, most significant position first
  localparam logic [ValW-1:0] DecMult [NumDigits][10] = '{
    '{17'd0, 17'd10000, 17'd20000, 17'd30000, 17'd40000,
      17'd50000, 17'd60000, 17'd70000, 17'd80000, 17'd90000},
    '{17'd0, 17'd1000, 17'd2000, 17'd3000, 17'd4000,
      17'd5000, 17'd6000, 17'd7000, 17'd8000, 17'd9000},
    '{17'd0, 17'd100, 17'd200, 17'd300, 17'd400,
      17'd500, 17'd600, 17'd700, 17'd800, 17'd900},
    '{17'd0, 17'd10, 17'd20, 17'd30, 17'd40,
      17'd50, 17'd60, 17'd70, 17'd80, 17'd90},
    '{17'd0, 17'd1, 17'd2, 17'd3, 17'd4,
      17'd5, 17'd6, 17'd7, 17'd8, 17'd9}
  };

  localparam logic [7:0] FontLarge [10][10] = '{
    '{8'h3C, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h3C},
    '{8'h18, 8'h38, 8'h18, 8'h18, 8'h18, 8'h18, 8'h18, 8'h18, 8'h18, 8'h7E},
    '{8'h3C, 8'h66, 8'h06, 8'h06, 8'h0C, 8'h18, 8'h30, 8'h60, 8'h60, 8'h7E},
    '{8'h3C, 8'h66, 8'h06, 8'h06, 8'h1C, 8'h06, 8'h06, 8'h06, 8'h66, 8'h3C},
    '{8'h0C, 8'h1C, 8'h2C, 8'h4C, 8'h4C, 8'h7E, 8'h0C, 8'h0C, 8'h0C, 8'h0C},
    '{8'h7E, 8'h60, 8'h60, 8'h60, 8'h7C, 8'h06, 8'h06, 8'h06, 8'h66, 8'h3C},
    '{8'h3C, 8'h66, 8'h60, 8'h60, 8'h7C, 8'h66, 8'h66, 8'h66, 8'h66, 8'h3C},
    '{8'h7E, 8'h06, 8'h06, 8'h0C, 8'h0C, 8'h18, 8'h18, 8'h18, 8'h18, 8'h18},
    '{8'h3C, 8'h66, 8'h66, 8'h66, 8'h3C, 8'h66, 8'h66, 8'h66, 8'h66, 8'h3C},
    '{8'h3C, 8'h66, 8'h66, 8'h66, 8'h3E, 8'h06, 8'h06, 8'h06, 8'h66, 8'h3C}
  };

  localparam logic [4:0] FontSmall [10][7] = '{
    '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
    '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
    '{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F},
    '{5'h0E, 5'h11, 5'h01, 5'h06, 5'h01, 5'h11, 5'h0E},
    '{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
    '{5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E},
    '{5'h0E, 5'h11, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
    '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h04, 5'h08, 5'h08},
    '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
    '{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h11, 5'h0E}
  };

  // glyph row left-aligned in eight columns, bit 7 is column zero
  function automatic logic [7:0] font_row(input logic big_font, input logic [3:0] digit,
                                          input logic [3:0] row);
    logic [7:0] bits;
    bits = 8'h00;
    if (digit <= 4'd9) begin
      if (big_font) begin
        if (row <= 4'd9) bits = FontLarge[digit][row];
      end else begin
        if (row <= 4'd6) bits = {FontSmall[digit][row[2:0]], 3'b000};
      end
    end
    return bits;
  endfunction

  // half the string width, rounded down, per digit count
  function automatic logic [3:0] half_span(input logic [2:0] ndig);
    logic [3:0] span;
    unique case (ndig)
      3'd1:    span = 4'd4;
      3'd2:    span = 4'd8;
      3'd3:    span = 4'd8;
      3'd4:    span = 4'd11;
      3'd5:    span = 4'd14;
      default: span = 4'd0;
    endcase
    return span;
  endfunction

endpackage

// ----- hw/rtl/dgr_item_if.sv -----
// input item channel: number, center point and color
interface dgr_item_if;
  logic               valid;
  logic               ready;
  logic signed [11:0] center_x;
  logic signed [11:0] center_y;
  logic signed [17:0] number;
  logic [15:0]        ink_color;

  modport source (output valid, output center_x, output center_y, output number,
                  output ink_color, input ready);
  modport sink (input valid, input center_x, input center_y, input number,
                input ink_color, output ready);
endinterface

// ----- hw/rtl/dgr_row_if.sv -----
// result channel: one glyph row per transfer
interface dgr_row_if;
  logic               valid;
  logic               ready;
  logic signed [12:0] start_x;
  logic signed [12:0] row_y;
  logic [19:0]        row_base;
  logic [7:0]         pixel_mask;
  logic [15:0]        out_color;
  logic               last_row;

  modport source (output valid, output start_x, output row_y, output row_base,
                  output pixel_mask, output out_color, output last_row, input ready);
  modport sink (input valid, input start_x, input row_y, input row_base,
                input pixel_mask, input out_color, input last_row, output ready);
endinterface

// ----- hw/rtl/dgr_front.sv -----
// front end: accepts items, drops non-positive numbers, converts to digits
module dgr_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  dgr_item_if.sink         item_i,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output dgr_pkg::dgr_job_t push_job_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StPush = 2'd2;

  logic [1:0]                state_q, state_d;
  logic [2:0]                step_q, step_d;
  logic [2:0]                wr_q, wr_d;
  logic [dgr_pkg::ValW-1:0]  val_q, val_d;
  dgr_pkg::dgr_job_t         job_q, job_d;

  logic                      item_fire;
  logic                      positive;
  logic [dgr_pkg::ValW-1:0]  num_abs;
  logic [2:0]                ndig;
  logic                      big_font;
  logic [3:0]                digit;
  logic [3:0]                shown_pos;

  assign item_i.ready = (state_q == StIdle);
  assign item_fire    = item_i.valid && item_i.ready;
  assign positive     = !item_i.number[17] && (item_i.number != 18'sd0);
  assign num_abs      = item_i.number[16:0];

  always_comb begin
    priority if (num_abs < 17'd10) ndig = 3'd1;
    else if (num_abs < 17'd100)     ndig = 3'd2;
    else if (num_abs < 17'd1000)    ndig = 3'd3;
    else if (num_abs < 17'd10000)   ndig = 3'd4;
    else                            ndig = 3'd5;
  end
  assign big_font = (ndig <= 3'd2);

  // one decimal digit per cycle by parallel compares against its multiples
  always_comb begin
    digit = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (val_q >= dgr_pkg::DecMult[step_q][k]) digit = 4'(k);
    end
  end

  assign shown_pos = {1'b0, step_q} + {1'b0, job_q.ndig};

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    wr_d    = wr_q;
    val_d   = val_q;
    job_d   = job_q;
    unique case (state_q)
      StIdle: begin
        if (item_fire && positive) begin
          state_d        = StConv;
          step_d         = 3'd0;
          wr_d           = 3'd0;
          val_d          = (num_abs >= dgr_pkg::Wrap) ? num_abs - dgr_pkg::Wrap : num_abs;
          job_d.ndig     = ndig;
          job_d.big_font = big_font;
          job_d.color    = item_i.ink_color;
          job_d.org_x    = {item_i.center_x[11], item_i.center_x}
                           - $signed({9'd0, dgr_pkg::half_span(ndig)});
          job_d.org_y    = {item_i.center_y[11], item_i.center_y}
                           - (big_font ? 13'sd5 : 13'sd3);
        end
      end
      StConv: begin
        val_d = val_q - dgr_pkg::DecMult[step_q][digit];
        // leading positions beyond the digit count are not drawn
        if (shown_pos >= 4'd5) begin
          job_d.digits[wr_q] = digit;
          wr_d = wr_q + 3'd1;
        end
        step_d = step_q + 3'd1;
        if (step_q == 3'(dgr_pkg::NumDigits - 1)) state_d = StPush;
      end
      StPush: begin
        if (push_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign push_valid_o = (state_q == StPush);
  assign push_job_o   = job_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= 3'd0;
      wr_q    <= 3'd0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      wr_q    <= wr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    job_q <= job_d;
  end

endmodule

// ----- hw/rtl/dgr_fifo.sv -----
// two-entry job queue between the front end and the row generator
module dgr_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  dgr_pkg::dgr_job_t push_job_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output dgr_pkg::dgr_job_t pop_job_o
);

  dgr_pkg::dgr_job_t                mem_q [dgr_pkg::FifoDepth];
  logic [dgr_pkg::FifoPtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [dgr_pkg::FifoCntW-1:0]     cnt_q;
  logic                             push, pop;

  assign push_ready_o = (cnt_q != dgr_pkg::FifoCntW'(dgr_pkg::FifoDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_job_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      unique case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_job_i;
  end

endmodule

// ----- hw/rtl/dgr_back.sv -----
// back end: walks digits and glyph rows, clips and emits one row per cycle while the output is not stalled
module dgr_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dgr_pkg::dgr_cfg_t cfg_i,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  dgr_pkg::dgr_job_t pop_job_i,
  dgr_row_if.source         row_o
);

  logic                             busy_q;
  logic signed [12:0]               ox_q, py_q, org_y_q;
  logic [2:0]                       dcnt_q, ndig_q;
  logic [3:0]                       rcnt_q;
  logic                             large_q;
  logic [dgr_pkg::NumDigits-1:0][3:0] digits_q;
  logic [15:0]                      color_q;

  logic                             out_valid_q;
  logic signed [12:0]               start_x_q, row_y_q;
  logic [19:0]                      row_base_q;
  logic [7:0]                       pixel_mask_q;
  logic [15:0]                      out_color_q;
  logic                             last_row_q;

  logic        load, emit;
  logic [7:0]  glyph_bits;
  logic        row_vis;
  logic [7:0]  mask;
  logic [13:0] px;
  logic [21:0] product;
  logic [19:0] base;
  logic [3:0]  row_last;
  logic        digit_done, job_done;

  assign pop_ready_o = !busy_q;
  assign load        = pop_valid_i && !busy_q;
  assign emit        = busy_q && (!out_valid_q || row_o.ready);

  assign glyph_bits = dgr_pkg::font_row(large_q, digits_q[0], rcnt_q);
  assign row_vis    = !py_q[12] && (py_q[11:0] < {1'b0, cfg_i.buf_height});

  always_comb begin
    mask = 8'h00;
    px   = '0;
    for (int c = 0; c < 8; c++) begin
      px = {ox_q[12], ox_q} + 14'(c);
      if (glyph_bits[7-c] && row_vis && !px[13] &&
          (px[12:0] < {2'b00, cfg_i.buf_width})) begin
        mask[7-c] = 1'b1;
      end
    end
  end

  // visible rows are below 2048, so the low eleven bits carry the row index
  assign product = {11'd0, py_q[10:0]} * {11'd0, cfg_i.row_stride};
  assign base    = row_vis ? product[19:0] : 20'd0;

  assign row_last   = large_q ? 4'd9 : 4'd6;
  assign digit_done = (rcnt_q == row_last);
  assign job_done   = digit_done && (dcnt_q == ndig_q - 3'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      dcnt_q      <= 3'd0;
      rcnt_q      <= 4'd0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
        dcnt_q <= 3'd0;
        rcnt_q <= 4'd0;
      end else if (emit) begin
        if (digit_done) begin
          rcnt_q <= 4'd0;
          dcnt_q <= dcnt_q + 3'd1;
          if (job_done) busy_q <= 1'b0;
        end else begin
          rcnt_q <= rcnt_q + 4'd1;
        end
      end
      if (emit) out_valid_q <= 1'b1;
      else if (row_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ox_q     <= pop_job_i.org_x;
      py_q     <= pop_job_i.org_y;
      org_y_q  <= pop_job_i.org_y;
      ndig_q   <= pop_job_i.ndig;
      large_q  <= pop_job_i.big_font;
      digits_q <= pop_job_i.digits;
      color_q  <= pop_job_i.color;
    end else if (emit) begin
      if (digit_done) begin
        py_q     <= org_y_q;
        ox_q     <= ox_q + (large_q ? 13'sd9 : 13'sd6);
        digits_q <= digits_q >> 4;
      end else begin
        py_q <= py_q + 13'sd1;
      end
    end
    if (emit) begin
      start_x_q    <= ox_q;
      row_y_q      <= py_q;
      row_base_q   <= base;
      pixel_mask_q <= mask;
      out_color_q  <= color_q;
      last_row_q   <= job_done;
    end
  end

  assign row_o.valid      = out_valid_q;
  assign row_o.start_x    = start_x_q;
  assign row_o.row_y      = row_y_q;
  assign row_o.row_base   = row_base_q;
  assign row_o.pixel_mask = pixel_mask_q;
  assign row_o.out_color  = out_color_q;
  assign row_o.last_row   = last_row_q;

endmodule

// ----- hw/rtl/decimal_digit_glyph_renderer_top.sv -----
// top level: register port, front end, job queue and row generator
// The first row follows the digit conversion, the job queue and the row output register;
// the rows of a number then follow one per cycle while the receiver is ready. The front end
// converts the next number while rows are emitted and runs ahead by up to three jobs.
// Non-positive numbers are dropped with no result.
// rst_ni clears all control state asynchronously; registers return to 256, 192, 256.
module decimal_digit_glyph_renderer_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  dgr_item_if.sink                    item_i,
  dgr_row_if.source                   row_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dgr_pkg::AddrW-1:0]   paddr,
  input  logic [dgr_pkg::DataW-1:0]   pwdata,
  output logic [dgr_pkg::DataW-1:0]   prdata,
  output logic                        pready
);

  dgr_pkg::dgr_cfg_t cfg_q;
  logic              cfg_write;

  logic              push_valid, push_ready, pop_valid, pop_ready;
  dgr_pkg::dgr_job_t push_job, pop_job;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.buf_width  <= dgr_pkg::BufWidthRst;
      cfg_q.buf_height <= dgr_pkg::BufHeightRst;
      cfg_q.row_stride <= dgr_pkg::RowStrideRst;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        dgr_pkg::RegBufWidth:  cfg_q.buf_width  <= pwdata[dgr_pkg::CfgW-1:0];
        dgr_pkg::RegBufHeight: cfg_q.buf_height <= pwdata[dgr_pkg::CfgW-1:0];
        dgr_pkg::RegRowStride: cfg_q.row_stride <= pwdata[dgr_pkg::CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      dgr_pkg::RegBufWidth:  prdata = {21'd0, cfg_q.buf_width};
      dgr_pkg::RegBufHeight: prdata = {21'd0, cfg_q.buf_height};
      dgr_pkg::RegRowStride: prdata = {21'd0, cfg_q.row_stride};
      default:               prdata = '0;
    endcase
  end

  dgr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job)
  );

  dgr_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  dgr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_job_i   (pop_job),
    .row_o       (row_o)
  );

endmodule

// ----- dv/glyph_row_checker.sv -----
// glyph row predictor and scoreboard for the decimal digit glyph renderer
module glyph_row_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  dgr_item_if                       item_mon,
  dgr_row_if                        row_mon,
  input  logic                      psel_i,
  input  logic                      penable_i,
  input  logic                      pwrite_i,
  input  logic [dgr_pkg::AddrW-1:0] paddr_i,
  input  logic [dgr_pkg::DataW-1:0] pwdata_i,
  input  logic [dgr_pkg::DataW-1:0] prdata_i,
  input  logic                      pready_i,
  output int                        mismatch_count_o,
  output int                        rows_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [12:0] start_x;
    logic signed [12:0] row_y;
    logic [19:0]        row_base;
    logic [7:0]         pixel_mask;
    logic [15:0]        out_color;
    logic               last_row;
  } glyph_row_t;

  localparam logic [7:0] DigitRowsLarge [10][10] = '{
    '{8'h3C, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h3C},
    '{8'h18, 8'h38, 8'h18, 8'h18, 8'h18, 8'h18, 8'h18, 8'h18, 8'h18, 8'h7E},
    '{8'h3C, 8'h66, 8'h06, 8'h06, 8'h0C, 8'h18, 8'h30, 8'h60, 8'h60, 8'h7E},
    '{8'h3C, 8'h66, 8'h06, 8'h06, 8'h1C, 8'h06, 8'h06, 8'h06, 8'h66, 8'h3C},
    '{8'h0C, 8'h1C, 8'h2C, 8'h4C, 8'h4C, 8'h7E, 8'h0C, 8'h0C, 8'h0C, 8'h0C},
    '{8'h7E, 8'h60, 8'h60, 8'h60, 8'h7C, 8'h06, 8'h06, 8'h06, 8'h66, 8'h3C},
    '{8'h3C, 8'h66, 8'h60, 8'h60, 8'h7C, 8'h66, 8'h66, 8'h66, 8'h66, 8'h3C},
    '{8'h7E, 8'h06, 8'h06, 8'h0C, 8'h0C, 8'h18, 8'h18, 8'h18, 8'h18, 8'h18},
    '{8'h3C, 8'h66, 8'h66, 8'h66, 8'h3C, 8'h66, 8'h66, 8'h66, 8'h66, 8'h3C},
    '{8'h3C, 8'h66, 8'h66, 8'h66, 8'h3E, 8'h06, 8'h06, 8'h06, 8'h66, 8'h3C}
  };

  localparam logic [4:0] DigitRowsNarrow [10][7] = '{
    '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
    '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
    '{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F},
    '{5'h0E, 5'h11, 5'h01, 5'h06, 5'h01, 5'h11, 5'h0E},
    '{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
    '{5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E},
    '{5'h0E, 5'h11, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
    '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h04, 5'h08, 5'h08},
    '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
    '{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h11, 5'h0E}
  };

  logic [dgr_pkg::CfgW-1:0] width_reg  = dgr_pkg::BufWidthRst;
  logic [dgr_pkg::CfgW-1:0] height_reg = dgr_pkg::BufHeightRst;
  logic [dgr_pkg::CfgW-1:0] stride_reg = dgr_pkg::RowStrideRst;
  glyph_row_t               expected_rows [$];
  int                       fail_total   = 0;
  int                       pending_rows = 0;

  assign mismatch_count_o = fail_total;
  assign rows_pending_o   = pending_rows;

  // queues every glyph row that one number produces under the current registers
  function automatic void predict_glyph_rows(logic signed [11:0] cx, logic signed [11:0] cy,
                                             logic signed [17:0] num, logic [15:0] color);
    int         value, ndig, gw, gh, left, top_y, ox, py, px, prod;
    int         vis_w, vis_h, stride, d, r, c;
    int         digit [5];
    logic [7:0] bits;
    logic       big_font;
    glyph_row_t row;
    if (num <= 0) return;
    value  = num;
    vis_w  = width_reg;
    vis_h  = height_reg;
    stride = stride_reg;
    if (value < 10) ndig = 1;
    else if (value < 100) ndig = 2;
    else if (value < 1000) ndig = 3;
    else if (value < 10000) ndig = 4;
    else ndig = 5;
    // six-digit numbers keep only their lower five digits
    for (d = ndig - 1; d >= 0; d--) begin
      digit[d] = value % 10;
      value    = value / 10;
    end
    big_font = (ndig <= 2);
    gw       = big_font ? 8 : 5;
    gh       = big_font ? 10 : 7;
    left     = cx - (ndig * gw + ndig - 1) / 2;
    top_y    = cy - gh / 2;
    for (d = 0; d < ndig; d++) begin
      ox = left + d * (gw + 1);
      for (r = 0; r < gh; r++) begin
        py   = top_y + r;
        bits = big_font ? DigitRowsLarge[digit[d]][r] : {DigitRowsNarrow[digit[d]][r], 3'b000};
        row.start_x    = ox[12:0];
        row.row_y      = py[12:0];
        row.row_base   = '0;
        row.pixel_mask = '0;
        if (py >= 0 && py < vis_h) begin
          prod         = py * stride;
          row.row_base = prod[19:0];
          for (c = 0; c < 8; c++) begin
            px = ox + c;
            if (bits[7-c] && px >= 0 && px < vis_w) row.pixel_mask[7-c] = 1'b1;
          end
        end
        row.out_color = color;
        row.last_row  = (d == ndig - 1) && (r == gh - 1);
        expected_rows.push_back(row);
      end
    end
  endfunction

  function automatic int field_error(string name, int expected_v, int actual_v);
    if (expected_v == actual_v) return 0;
    $error("%s: expected %0d, actual %0d", name, expected_v, actual_v);
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    glyph_row_t                exp_row;
    logic [dgr_pkg::DataW-1:0] reg_value;
    logic                      reg_known;
    if (!rst_ni) begin
      width_reg  <= dgr_pkg::BufWidthRst;
      height_reg <= dgr_pkg::BufHeightRst;
      stride_reg <= dgr_pkg::RowStrideRst;
      expected_rows.delete();
      pending_rows = 0;
    end else begin
      if (row_mon.valid && row_mon.ready) begin
        if (expected_rows.size() == 0) begin
          $error("row transfer with nothing expected: start_x %0d, row_y %0d",
                 row_mon.start_x, row_mon.row_y);
          fail_total++;
        end else begin
          exp_row = expected_rows.pop_front();
          fail_total += field_error("start_x", exp_row.start_x, row_mon.start_x)
                      + field_error("row_y", exp_row.row_y, row_mon.row_y)
                      + field_error("row_base", exp_row.row_base, row_mon.row_base)
                      + field_error("pixel_mask", exp_row.pixel_mask, row_mon.pixel_mask)
                      + field_error("out_color", exp_row.out_color, row_mon.out_color)
                      + field_error("last_row", exp_row.last_row, row_mon.last_row);
        end
      end
      if (item_mon.valid && item_mon.ready) begin
        predict_glyph_rows(item_mon.center_x, item_mon.center_y, item_mon.number,
                           item_mon.ink_color);
      end
      if (psel_i && penable_i && pready_i) begin
        reg_value = '0;
        reg_known = 1'b1;
        case (paddr_i[dgr_pkg::AddrW-1:2])
          dgr_pkg::RegBufWidth:  reg_value[dgr_pkg::CfgW-1:0] = width_reg;
          dgr_pkg::RegBufHeight: reg_value[dgr_pkg::CfgW-1:0] = height_reg;
          dgr_pkg::RegRowStride: reg_value[dgr_pkg::CfgW-1:0] = stride_reg;
          default:               reg_known = 1'b0;
        endcase
        if (pwrite_i) begin
          case (paddr_i[dgr_pkg::AddrW-1:2])
            dgr_pkg::RegBufWidth:  width_reg  <= pwdata_i[dgr_pkg::CfgW-1:0];
            dgr_pkg::RegBufHeight: height_reg <= pwdata_i[dgr_pkg::CfgW-1:0];
            dgr_pkg::RegRowStride: stride_reg <= pwdata_i[dgr_pkg::CfgW-1:0];
            default: ;
          endcase
        end else if (reg_known) begin
          fail_total += field_error("prdata", reg_value, prdata_i);
        end
      end
      pending_rows = expected_rows.size();
    end
  end

endmodule

// ----- dv/decimal_digit_glyph_renderer_top_test.sv -----
// stimulus, register programming and verdict for the decimal digit glyph renderer
module decimal_digit_glyph_renderer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         ResetCycles   = 10;
  localparam int         DrainCycles   = 24;
  localparam int         HoldCycles    = 600;
  localparam int         WatchdogLimit = 4000;
  localparam int         NumPhases     = 7;
  localparam int         ItemsPerPhase = 52;
  localparam logic [1:0] RegUnused     = 2'd3;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [dgr_pkg::AddrW-1:0] paddr;
  logic [dgr_pkg::DataW-1:0] pwdata;
  logic [dgr_pkg::DataW-1:0] prdata;
  logic                      pready;
  int                        send_idle_pct = 37;
  int                        recv_idle_pct = 81;
  bit                        hold_rows     = 1'b0;
  int                        cur_width     = dgr_pkg::BufWidthRst;
  int                        cur_height    = dgr_pkg::BufHeightRst;
  int                        mismatches;
  int                        rows_pending;

  dgr_item_if item_if ();
  dgr_row_if  row_if ();

  decimal_digit_glyph_renderer_top u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_if),
    .row_o   (row_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  glyph_row_checker u_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_mon         (item_if),
    .row_mon          (row_if),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .prdata_i         (prdata),
    .pready_i         (pready),
    .mismatch_count_o (mismatches),
    .rows_pending_o   (rows_pending)
  );

  always #10 clk_i = ~clk_i;

  // row receiver, with one long hold-off on request so the block backs up
  initial begin
    row_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_rows) begin
        row_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_rows = 1'b0;
      end
      row_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((item_if.valid && item_if.ready) || (row_if.valid && row_if.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  task automatic apb_access(input logic write, input logic [1:0] index,
                            input logic [dgr_pkg::DataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {index, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_registers(input logic [dgr_pkg::DataW-1:0] w,
                                   input logic [dgr_pkg::DataW-1:0] h,
                                   input logic [dgr_pkg::DataW-1:0] s);
    apb_access(1'b1, dgr_pkg::RegBufWidth, w);
    apb_access(1'b1, dgr_pkg::RegBufHeight, h);
    apb_access(1'b1, dgr_pkg::RegRowStride, s);
    cur_width  = w[dgr_pkg::CfgW-1:0];
    cur_height = h[dgr_pkg::CfgW-1:0];
  endtask

  task automatic read_registers();
    apb_access(1'b0, dgr_pkg::RegBufWidth, '0);
    apb_access(1'b0, dgr_pkg::RegBufHeight, '0);
    apb_access(1'b0, dgr_pkg::RegRowStride, '0);
    apb_access(1'b0, RegUnused, '0);
  endtask

  // called at a rising edge, returns at the edge of the transfer
  task automatic offer_item(input logic signed [11:0] cx, input logic signed [11:0] cy,
                            input logic signed [17:0] num, input logic [15:0] color);
    if ($urandom_range(99) < send_idle_pct) begin
      item_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    item_if.valid     <= 1'b1;
    item_if.center_x  <= cx;
    item_if.center_y  <= cy;
    item_if.number    <= num;
    item_if.ink_color <= color;
    do @(posedge clk_i); while (!(item_if.valid && item_if.ready));
  endtask

  task automatic random_items(input int count);
    int                 drawn, sel, hi_x, hi_y;
    logic signed [11:0] cx, cy;
    logic signed [17:0] num;
    drawn = 0;
    while (drawn < count) begin
      sel = $urandom_range(99);
      if (sel < 8) num = 18'(-int'($urandom_range(131072)));
      else if (sel < 30) num = 18'($urandom_range(99, 1));
      else if (sel < 82) num = 18'($urandom_range(99999, 100));
      else num = 18'($urandom);
      // mostly around the visible area so clipping edges get hit
      if ($urandom_range(99) < 70) begin
        hi_x = (cur_width + 24 > 2047) ? 2047 : cur_width + 24;
        hi_y = (cur_height + 16 > 2047) ? 2047 : cur_height + 16;
        cx   = 12'(int'($urandom_range(hi_x + 24)) - 24);
        cy   = 12'(int'($urandom_range(hi_y + 16)) - 16);
      end else begin
        cx = 12'($urandom);
        cy = 12'($urandom);
      end
      offer_item(cx, cy, num, 16'($urandom));
      drawn++;
    end
  endtask

  task automatic directed_items();
    offer_item(128, 96, 0, 16'h0000);
    offer_item(128, 96, -1, 16'hFFFF);
    offer_item(-2048, -2048, -131072, 16'h1234);
    offer_item(128, 96, 7, 16'hFFFF);
    offer_item(128, 96, 12, 16'h0000);
    offer_item(128, 96, 34, 16'hA5A5);
    offer_item(128, 96, 56, 16'h5A5A);
    offer_item(128, 96, 78, 16'h0F0F);
    offer_item(128, 96, 90, 16'hF0F0);
    // partly off the left edge
    offer_item(2, 5, 99, 16'h00FF);
    // partly off the right and bottom edges
    offer_item(254, 190, 100, 16'hFF00);
    offer_item(-2048, -2048, 999, 16'h8001);
    offer_item(2047, 2047, 9999, 16'h7FFE);
    offer_item(128, 96, 10000, 16'h1111);
    offer_item(128, 96, 12345, 16'h2222);
    offer_item(128, 96, 67890, 16'h4444);
    // six digits: only the lower five are drawn
    offer_item(0, 96, 131071, 16'hFFFF);
    offer_item(255, 0, 100000, 16'h0000);
  endtask

  task automatic drain();
    item_if.valid <= 1'b0;
    @(posedge clk_i);
    wait (rows_pending == 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    rst_ni            <= 1'b0;
    item_if.valid     <= 1'b0;
    item_if.center_x  <= '0;
    item_if.center_y  <= '0;
    item_if.number    <= '0;
    item_if.ink_color <= '0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        1: program_registers(32'd1024, 32'd1024, 32'd1024);
        2: begin
          program_registers(32'd1, 32'd1, 32'd1);
          apb_access(1'b1, RegUnused, 32'h0000_05A5);
        end
        3: program_registers('1, '1, '1);
        4: program_registers(32'd0, $urandom_range(1024, 1), $urandom_range(1024, 1));
        5: program_registers($urandom_range(1024, 1), 32'd0, $urandom_range(1024, 1));
        6: program_registers($urandom_range(1024, 1), $urandom_range(1024, 1),
                             $urandom_range(1024, 1));
        default: ;
      endcase
      read_registers();
      if (p < 2) begin
        send_idle_pct = 37;
        recv_idle_pct = 81;
      end else if (p < 4) begin
        send_idle_pct = 81;
        recv_idle_pct = 37;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p == 0) directed_items();
      if (p == NumPhases - 1) hold_rows = 1'b1;
      random_items(ItemsPerPhase);
      drain();
    end
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
